### design/lav_pkg.sv
// Shared constants and types for the look-at view matrix block.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package lav_pkg;

	localparam int FRAC_BITS_DEF = 16;   // default Q format fraction bits
	localparam int COORD_W       = 32;   // width of every coordinate port
	localparam int NORM_BITS     = 30;   // largest scaled magnitude lies in [2^29, 2^30)
	localparam int SQ_W          = 2 * NORM_BITS + 2;  // sum of three squares
	localparam int ROOT_W        = NORM_BITS + 1;      // floor sqrt of that sum
	localparam int SQRT_SPS      = 2;    // square root steps per pipeline stage
	localparam int DIV_SPS       = 2;    // quotient bits per pipeline stage

	typedef enum logic [1:0] {
		ROW_SIDE = 2'd0,
		ROW_UP   = 2'd1,
		ROW_FWD  = 2'd2,
		ROW_HOM  = 2'd3
	} row_t;

	// status that travels with a normalised vector
	typedef struct packed {
		logic valid;
		logic zero;
	} nrm_stat_t;

endpackage

`default_nettype wire

### design/look_at_view_matrix_top.sv
// Look-at view matrix builder: top level, cross products, dot products, row output.
// Depends on lav_pkg, lav_norm (and through it lav_isqrt).
//
//  channel   | handshake                 | contents
//  ----------+---------------------------+-------------------------------------------
//  request   | start, accepted if !busy  | eye_*, target_*, up_* (signed Q16.16)
//  result    | row_valid, one cycle each | row_index, col0..col3, degenerate, last_row
//
// After an accepted request busy stays high while gap_q counts down, because the four
// rows share the single result port; a new request is taken only once busy is low.
// Inside, everything is a free-running pipeline (three normalisers built from
// scale, square, pipelined square root and pipelined divider); valid bits follow
// the data, nothing stalls. Row 0 shows up after stage 1, the forward and up normalisers,
// the f x up stages, the side normaliser, stages 4 to 8 and the row registers; rows 1..3
// follow back to back. The receiver cannot hold rows off. Reset clears only valid and
// status bits, the row sequencer and busy.
`timescale 1ns / 1ps
`default_nettype none

module look_at_view_matrix_top #(
	parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	output logic               row_valid,
	output logic [1:0]         row_index,
	output logic signed [31:0] col0,
	output logic signed [31:0] col1,
	output logic signed [31:0] col2,
	output logic signed [31:0] col3,
	output logic               degenerate,
	output logic               last_row
);

	localparam int CW    = lav_pkg::COORD_W;
	localparam int UW    = FRAC_BITS + 2;     // unit vector component
	localparam int PW    = 2 * UW;            // product of two unit components
	localparam int RAW_W = PW + 1;            // cross product term
	localparam int UUW   = FRAC_BITS + 3;     // rounded s x f component
	localparam int DW    = FRAC_BITS + 36;    // dot product with eye
	localparam int SP_W  = 1 + 3 * CW + 3 * UW;

	localparam logic [DW-1:0] HALF = DW'(1) << (FRAC_BITS - 1);
	localparam logic signed [DW-1:0] SMAX = $signed({{(DW-CW){1'b0}}, 32'h7FFF_FFFF});
	localparam logic signed [DW-1:0] SMIN = $signed({{(DW-CW){1'b1}}, 32'h8000_0000});
	localparam logic signed [CW-1:0] ONE  = CW'(1) << FRAC_BITS;

	// shift right by FRAC_BITS, halves away from zero
	function automatic logic signed [DW-1:0] rnd_shift(input logic signed [DW-1:0] v);
		logic [DW-1:0] mag;
		mag = v[DW-1] ? DW'(-v) : DW'(v);
		mag = (mag + HALF) >> FRAC_BITS;
		return v[DW-1] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [CW-1:0] sat32(input logic signed [DW-1:0] v);
		if (v > SMAX) return SMAX[CW-1:0];
		if (v < SMIN) return SMIN[CW-1:0];
		return v[CW-1:0];
	endfunction

	// request acceptance and spacing
	logic       accept;
	logic [1:0] gap_q;

	assign accept = start && !busy;
	assign busy   = (gap_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 2'd0;
		end else if (accept) begin
			gap_q <= 2'd3;
		end else if (gap_q != 2'd0) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	// ---- stage 1: capture the request
	logic                 v_s1;
	logic signed [CW-1:0] eye_s1 [3];
	logic signed [CW-1:0] tgt_s1 [3];
	logic signed [CW-1:0] up_s1  [3];
	logic signed [CW:0]   d_c    [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		eye_s1 <= '{eye_x, eye_y, eye_z};
		tgt_s1 <= '{target_x, target_y, target_z};
		up_s1  <= '{up_x, up_y, up_z};
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i] = {tgt_s1[i][CW-1], tgt_s1[i]} - {eye_s1[i][CW-1], eye_s1[i]};
		end
	end

	// ---- forward and up normalisers run side by side
	lav_pkg::nrm_stat_t   f_st, u_st, s_st;
	logic signed [UW-1:0] f_vec  [3];
	logic signed [UW-1:0] un_vec [3];
	logic signed [UW-1:0] s_vec  [3];
	logic [2*CW-1:0]      f_pay;
	logic [CW-1:0]        u_pay;
	logic [SP_W-1:0]      s_pay;

	lav_norm #(
		.IN_W     (CW + 1),
		.FRAC_BITS(FRAC_BITS),
		.PAY_W    (2 * CW)
	) u_fnorm (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(v_s1),
		.in_vec  (d_c),
		.in_pay  ({eye_s1[0], eye_s1[1]}),
		.out_stat(f_st),
		.out_vec (f_vec),
		.out_pay (f_pay)
	);

	lav_norm #(
		.IN_W     (CW),
		.FRAC_BITS(FRAC_BITS),
		.PAY_W    (CW)
	) u_unorm (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(v_s1),
		.in_vec  (up_s1),
		.in_pay  (eye_s1[2]),
		.out_stat(u_st),
		.out_vec (un_vec),
		.out_pay (u_pay)
	);

	// ---- stage 2/3: f x up
	logic                 v_s2, v_s3;
	logic signed [PW-1:0] p_s2   [6];
	logic signed [UW-1:0] f_s2   [3];
	logic signed [UW-1:0] f_s3   [3];
	logic signed [CW-1:0] eye_s2 [3];
	logic signed [CW-1:0] eye_s3 [3];
	logic                 deg_s2, deg_s3;
	logic signed [RAW_W-1:0] raw_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= f_st.valid && u_st.valid;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s2[0] <= f_vec[1] * un_vec[2];
		p_s2[1] <= f_vec[2] * un_vec[1];
		p_s2[2] <= f_vec[2] * un_vec[0];
		p_s2[3] <= f_vec[0] * un_vec[2];
		p_s2[4] <= f_vec[0] * un_vec[1];
		p_s2[5] <= f_vec[1] * un_vec[0];
		f_s2    <= f_vec;
		eye_s2  <= '{f_pay[2*CW-1:CW], f_pay[CW-1:0], u_pay};
		deg_s2  <= f_st.zero || u_st.zero;
		for (int i = 0; i < 3; i++) begin
			raw_s3[i] <= RAW_W'(p_s2[2*i]) - RAW_W'(p_s2[2*i+1]);
		end
		f_s3   <= f_s2;
		eye_s3 <= eye_s2;
		deg_s3 <= deg_s2;
	end

	// ---- side vector normaliser, carrying eye, f and the flag
	lav_norm #(
		.IN_W     (RAW_W),
		.FRAC_BITS(FRAC_BITS),
		.PAY_W    (SP_W)
	) u_snorm (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(v_s3),
		.in_vec  (raw_s3),
		.in_pay  ({deg_s3, eye_s3[0], eye_s3[1], eye_s3[2], f_s3[0], f_s3[1], f_s3[2]}),
		.out_stat(s_st),
		.out_vec (s_vec),
		.out_pay (s_pay)
	);

	logic                 deg_a;
	logic signed [CW-1:0] eye_a [3];
	logic signed [UW-1:0] f_a   [3];

	assign {deg_a, eye_a[0], eye_a[1], eye_a[2], f_a[0], f_a[1], f_a[2]} = s_pay;

	// ---- stage 4: s x f products, s.eye and f.eye products
	logic                 v_s4, v_s5, v_s6, v_s7, v_s8;
	logic signed [PW-1:0] q_s4  [6];
	logic signed [DW-1:0] es_s4 [3];
	logic signed [DW-1:0] ef_s4 [3];
	logic signed [UW-1:0] s_s4 [3], s_s5 [3], s_s6 [3], s_s7 [3], s_s8 [3];
	logic signed [UW-1:0] f_s4 [3], f_s5 [3], f_s6 [3], f_s7 [3], f_s8 [3];
	logic signed [CW-1:0] eye_s4 [3], eye_s5 [3], eye_s6 [3];
	logic                 deg_s4, deg_s5, deg_s6, deg_s7, deg_s8;
	// stage 5: sums
	logic signed [RAW_W-1:0] raw2_s5 [3];
	logic signed [DW-1:0]    ds_s5, df_s5;
	// stage 6: rounding
	logic signed [UUW-1:0] u_s6 [3], u_s7 [3], u_s8 [3];
	logic signed [DW-1:0]  dsr_s6, dsr_s7, dsr_s8;
	logic signed [DW-1:0]  dfr_s6, dfr_s7, dfr_s8;
	// stage 7/8: u.eye
	logic signed [DW-1:0]  eu_s7 [3];
	logic signed [DW-1:0]  du_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s4 <= s_st.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		q_s4[0] <= s_vec[1] * f_a[2];
		q_s4[1] <= s_vec[2] * f_a[1];
		q_s4[2] <= s_vec[2] * f_a[0];
		q_s4[3] <= s_vec[0] * f_a[2];
		q_s4[4] <= s_vec[0] * f_a[1];
		q_s4[5] <= s_vec[1] * f_a[0];
		for (int i = 0; i < 3; i++) begin
			es_s4[i] <= DW'(s_vec[i]) * DW'(eye_a[i]);
			ef_s4[i] <= DW'(f_a[i]) * DW'(eye_a[i]);
		end
		s_s4   <= s_vec;
		f_s4   <= f_a;
		eye_s4 <= eye_a;
		deg_s4 <= deg_a || s_st.zero;

		for (int i = 0; i < 3; i++) begin
			raw2_s5[i] <= RAW_W'(q_s4[2*i]) - RAW_W'(q_s4[2*i+1]);
		end
		ds_s5  <= es_s4[0] + es_s4[1] + es_s4[2];
		df_s5  <= ef_s4[0] + ef_s4[1] + ef_s4[2];
		s_s5   <= s_s4;
		f_s5   <= f_s4;
		eye_s5 <= eye_s4;
		deg_s5 <= deg_s4;

		for (int i = 0; i < 3; i++) begin
			u_s6[i] <= UUW'(rnd_shift(DW'(raw2_s5[i])));
		end
		dsr_s6 <= rnd_shift(ds_s5);
		dfr_s6 <= rnd_shift(df_s5);
		s_s6   <= s_s5;
		f_s6   <= f_s5;
		eye_s6 <= eye_s5;
		deg_s6 <= deg_s5;

		for (int i = 0; i < 3; i++) begin
			eu_s7[i] <= DW'(u_s6[i]) * DW'(eye_s6[i]);
		end
		u_s7   <= u_s6;
		dsr_s7 <= dsr_s6;
		dfr_s7 <= dfr_s6;
		s_s7   <= s_s6;
		f_s7   <= f_s6;
		deg_s7 <= deg_s6;

		du_s8  <= eu_s7[0] + eu_s7[1] + eu_s7[2];
		u_s8   <= u_s7;
		dsr_s8 <= dsr_s7;
		dfr_s8 <= dfr_s7;
		s_s8   <= s_s7;
		f_s8   <= f_s7;
		deg_s8 <= deg_s7;
	end

	// ---- row holding registers and row sequencer
	logic signed [CW-1:0] mat_q [3][4];
	logic                 deg_q;
	logic                 act_q;
	lav_pkg::row_t        cnt_q;

	always_ff @(posedge clk) begin
		if (v_s8) begin
			for (int i = 0; i < 3; i++) begin
				mat_q[0][i] <= CW'(s_s8[i]);
				mat_q[1][i] <= CW'(u_s8[i]);
				mat_q[2][i] <= -CW'(f_s8[i]);
			end
			mat_q[0][3] <= sat32(-dsr_s8);
			mat_q[1][3] <= sat32(-rnd_shift(du_s8));
			mat_q[2][3] <= sat32(dfr_s8);
			deg_q       <= deg_s8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= lav_pkg::ROW_SIDE;
		end else if (v_s8) begin
			act_q <= 1'b1;
			cnt_q <= lav_pkg::ROW_SIDE;
		end else if (act_q) begin
			act_q <= (cnt_q != lav_pkg::ROW_HOM);
			cnt_q <= lav_pkg::row_t'(cnt_q + 2'd1);
		end
	end

	always_comb begin
		case (cnt_q)
			lav_pkg::ROW_SIDE: begin
				{col0, col1, col2, col3} = {mat_q[0][0], mat_q[0][1], mat_q[0][2], mat_q[0][3]};
			end
			lav_pkg::ROW_UP: begin
				{col0, col1, col2, col3} = {mat_q[1][0], mat_q[1][1], mat_q[1][2], mat_q[1][3]};
			end
			lav_pkg::ROW_FWD: begin
				{col0, col1, col2, col3} = {mat_q[2][0], mat_q[2][1], mat_q[2][2], mat_q[2][3]};
			end
			default: begin
				{col0, col1, col2, col3} = {{(3*CW){1'b0}}, ONE};
			end
		endcase
	end

	assign row_valid  = act_q;
	assign row_index  = cnt_q;
	assign degenerate = deg_q;
	assign last_row   = act_q && (cnt_q == lav_pkg::ROW_HOM);

endmodule

`default_nettype wire

### design/lav_isqrt.sv
// Pipelined integer square root, two result bits per stage, with side payload.
// Depends on lav_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lav_isqrt #(
	parameter int PAY_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [lav_pkg::SQ_W-1:0]    in_x,
	input  logic [PAY_W-1:0]            in_pay,
	output logic                        out_valid,
	output logic [lav_pkg::ROOT_W-1:0]  out_root,
	output logic [PAY_W-1:0]            out_pay
);

	localparam int XW    = lav_pkg::SQ_W;
	localparam int RW    = lav_pkg::ROOT_W;
	localparam int STEPS = XW / 2;
	localparam int SPS   = lav_pkg::SQRT_SPS;
	localparam int NSTG  = (STEPS + SPS - 1) / SPS;
	localparam int REM_W = RW + 3;

	logic             v_sn    [1:NSTG];
	logic [XW-1:0]    x_sn    [1:NSTG];
	logic [REM_W-1:0] rem_sn  [1:NSTG];
	logic [RW-1:0]    root_sn [1:NSTG];
	logic [PAY_W-1:0] pay_sn  [1:NSTG];

	for (genvar g = 0; g < NSTG; g++) begin : g_stg
		logic             v_c;
		logic [XW-1:0]    x_c, x_n;
		logic [REM_W-1:0] rem_c, rem_n;
		logic [RW-1:0]    root_c, root_n;
		logic [PAY_W-1:0] pay_c;

		if (g == 0) begin : g_first
			assign v_c    = in_valid;
			assign x_c    = in_x;
			assign rem_c  = '0;
			assign root_c = '0;
			assign pay_c  = in_pay;
		end else begin : g_rest
			assign v_c    = v_sn[g];
			assign x_c    = x_sn[g];
			assign rem_c  = rem_sn[g];
			assign root_c = root_sn[g];
			assign pay_c  = pay_sn[g];
		end

		// restoring digit recurrence: bring in two bits, try (root<<2)|1
		always_comb begin
			logic [REM_W-1:0] trial;
			logic [REM_W-1:0] cand;
			x_n    = x_c;
			rem_n  = rem_c;
			root_n = root_c;
			trial  = '0;
			cand   = '0;
			for (int k = 0; k < SPS; k++) begin
				if (g * SPS + k < STEPS) begin
					trial = {rem_n[REM_W-3:0], x_n[XW-1 -: 2]};
					cand  = {1'b0, root_n, 2'b01};
					if (trial >= cand) begin
						rem_n  = trial - cand;
						root_n = {root_n[RW-2:0], 1'b1};
					end else begin
						rem_n  = trial;
						root_n = {root_n[RW-2:0], 1'b0};
					end
					x_n = {x_n[XW-3:0], 2'b00};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[g+1] <= 1'b0;
			end else begin
				v_sn[g+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			x_sn[g+1]    <= x_n;
			rem_sn[g+1]  <= rem_n;
			root_sn[g+1] <= root_n;
			pay_sn[g+1]  <= pay_c;
		end
	end

	assign out_valid = v_sn[NSTG];
	assign out_root  = root_sn[NSTG];
	assign out_pay   = pay_sn[NSTG];

endmodule

`default_nettype wire

### design/lav_norm.sv
// Pipelined 3-vector normaliser: scale, sum of squares, square root, divide.
// Depends on lav_pkg and lav_isqrt.
`timescale 1ns / 1ps
`default_nettype none

module lav_norm #(
	parameter int IN_W      = 33,
	parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
	parameter int PAY_W     = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic signed [IN_W-1:0]    in_vec [3],
	input  logic [PAY_W-1:0]          in_pay,
	output lav_pkg::nrm_stat_t        out_stat,
	output logic signed [FRAC_BITS+1:0] out_vec [3],
	output logic [PAY_W-1:0]          out_pay
);

	localparam int NB    = lav_pkg::NORM_BITS;
	localparam int RW    = lav_pkg::ROOT_W;
	localparam int UW    = FRAC_BITS + 2;
	localparam int BL_W  = $clog2(IN_W + 1);
	localparam int Q_W   = FRAC_BITS + 1;
	localparam int NUM_W = NB + FRAC_BITS + 1;
	localparam int DR_W  = RW + 1;
	localparam int DSPS  = lav_pkg::DIV_SPS;
	localparam int NDS   = (Q_W + DSPS - 1) / DSPS;
	localparam int SP_W  = 3 * NB + 3 + 1 + PAY_W;

	// stage 1: magnitudes
	logic             v_s1;
	logic [IN_W-1:0]  mag_s1 [3];
	logic [2:0]       neg_s1;
	logic [PAY_W-1:0] pay_s1;
	// stage 2: bit length of the largest magnitude
	logic             v_s2;
	logic [IN_W-1:0]  mag_s2 [3];
	logic [2:0]       neg_s2;
	logic [BL_W-1:0]  bl_s2;
	logic             zero_s2;
	logic [PAY_W-1:0] pay_s2;
	// stage 3: scaled magnitudes
	logic             v_s3;
	logic [NB-1:0]    m_s3 [3];
	logic [2:0]       neg_s3;
	logic             zero_s3;
	logic [PAY_W-1:0] pay_s3;
	// stage 4: squares
	logic             v_s4;
	logic [2*NB-1:0]  sq_s4 [3];
	logic [NB-1:0]    m_s4 [3];
	logic [2:0]       neg_s4;
	logic             zero_s4;
	logic [PAY_W-1:0] pay_s4;
	// stage 5: sum
	logic                     v_s5;
	logic [lav_pkg::SQ_W-1:0] sum_s5;
	logic [NB-1:0]            m_s5 [3];
	logic [2:0]               neg_s5;
	logic                     zero_s5;
	logic [PAY_W-1:0]         pay_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	logic [IN_W-1:0] or_c;
	logic [BL_W-1:0] bl_c;

	always_comb begin
		or_c = mag_s1[0] | mag_s1[1] | mag_s1[2];
		bl_c = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (or_c[i]) bl_c = BL_W'(i + 1);
		end
	end

	logic [IN_W+NB-1:0] wide_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide_c[i] = {mag_s2[i], {NB{1'b0}}} >> bl_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= in_vec[i][IN_W-1] ? IN_W'(-in_vec[i]) : IN_W'(in_vec[i]);
			neg_s1[i] <= in_vec[i][IN_W-1];
			mag_s2[i] <= mag_s1[i];
			m_s3[i]   <= wide_c[i][NB-1:0];
			sq_s4[i]  <= m_s3[i] * m_s3[i];
			m_s4[i]   <= m_s3[i];
			m_s5[i]   <= m_s4[i];
		end
		pay_s1  <= in_pay;
		neg_s2  <= neg_s1;
		bl_s2   <= bl_c;
		zero_s2 <= (or_c == '0);
		pay_s2  <= pay_s1;
		neg_s3  <= neg_s2;
		zero_s3 <= zero_s2;
		pay_s3  <= pay_s2;
		neg_s4  <= neg_s3;
		zero_s4 <= zero_s3;
		pay_s4  <= pay_s3;
		sum_s5  <= lav_pkg::SQ_W'(sq_s4[0]) + lav_pkg::SQ_W'(sq_s4[1])
			+ lav_pkg::SQ_W'(sq_s4[2]);
		neg_s5  <= neg_s4;
		zero_s5 <= zero_s4;
		pay_s5  <= pay_s4;
	end

	// square root, carrying the scaled magnitudes alongside
	logic            sq_v;
	logic [RW-1:0]   len;
	logic [SP_W-1:0] sq_pay;
	logic [NB-1:0]   ms [3];
	logic [2:0]      negd;
	logic            zerod;
	logic [PAY_W-1:0] payd;

	lav_isqrt #(
		.PAY_W(SP_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s5),
		.in_x     (sum_s5),
		.in_pay   ({m_s5[0], m_s5[1], m_s5[2], neg_s5, zero_s5, pay_s5}),
		.out_valid(sq_v),
		.out_root (len),
		.out_pay  (sq_pay)
	);

	assign {ms[0], ms[1], ms[2], negd, zerod, payd} = sq_pay;

	// numerator m*2^F + len/2; its top bits seed the remainder
	logic [NUM_W-1:0] num_c  [3];
	logic [DR_W-1:0]  rem0_c [3];
	logic [Q_W-1:0]   low0_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i]  = NUM_W'({ms[i], {FRAC_BITS{1'b0}}}) + NUM_W'(len >> 1);
			rem0_c[i] = DR_W'(num_c[i][NUM_W-1 -: NB]);
			low0_c[i] = num_c[i][Q_W-1:0];
		end
	end

	logic             v_dn    [1:NDS];
	logic [RW-1:0]    len_dn  [1:NDS];
	logic [DR_W-1:0]  rem_dn  [1:NDS][3];
	logic [Q_W-1:0]   low_dn  [1:NDS][3];
	logic [Q_W-1:0]   q_dn    [1:NDS][3];
	logic [2:0]       neg_dn  [1:NDS];
	logic             zero_dn [1:NDS];
	logic [PAY_W-1:0] pay_dn  [1:NDS];

	for (genvar g = 0; g < NDS; g++) begin : g_div
		logic             v_c;
		logic [RW-1:0]    len_c;
		logic [DR_W-1:0]  rem_c [3];
		logic [Q_W-1:0]   low_c [3];
		logic [Q_W-1:0]   q_c   [3];
		logic [2:0]       neg_c;
		logic             zero_c;
		logic [PAY_W-1:0] pay_c;
		logic [DR_W-1:0]  rem_n [3];
		logic [Q_W-1:0]   low_n [3];
		logic [Q_W-1:0]   q_n   [3];

		if (g == 0) begin : g_first
			assign v_c    = sq_v;
			assign len_c  = len;
			assign rem_c  = rem0_c;
			assign low_c  = low0_c;
			assign q_c    = '{default: '0};
			assign neg_c  = negd;
			assign zero_c = zerod;
			assign pay_c  = payd;
		end else begin : g_rest
			assign v_c    = v_dn[g];
			assign len_c  = len_dn[g];
			assign rem_c  = rem_dn[g];
			assign low_c  = low_dn[g];
			assign q_c    = q_dn[g];
			assign neg_c  = neg_dn[g];
			assign zero_c = zero_dn[g];
			assign pay_c  = pay_dn[g];
		end

		always_comb begin
			logic [DR_W-1:0] t;
			t = '0;
			for (int i = 0; i < 3; i++) begin
				rem_n[i] = rem_c[i];
				low_n[i] = low_c[i];
				q_n[i]   = q_c[i];
				for (int k = 0; k < DSPS; k++) begin
					if (g * DSPS + k < Q_W) begin
						t        = {rem_n[i][DR_W-2:0], low_n[i][Q_W-1]};
						low_n[i] = {low_n[i][Q_W-2:0], 1'b0};
						if (t >= DR_W'(len_c)) begin
							rem_n[i] = t - DR_W'(len_c);
							q_n[i]   = {q_n[i][Q_W-2:0], 1'b1};
						end else begin
							rem_n[i] = t;
							q_n[i]   = {q_n[i][Q_W-2:0], 1'b0};
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dn[g+1] <= 1'b0;
			end else begin
				v_dn[g+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			len_dn[g+1]  <= len_c;
			rem_dn[g+1]  <= rem_n;
			low_dn[g+1]  <= low_n;
			q_dn[g+1]    <= q_n;
			neg_dn[g+1]  <= neg_c;
			zero_dn[g+1] <= zero_c;
			pay_dn[g+1]  <= pay_c;
		end
	end

	// restore signs; a zero vector stays zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stat <= '0;
		end else begin
			out_stat.valid <= v_dn[NDS];
			out_stat.zero  <= zero_dn[NDS];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (zero_dn[NDS]) begin
				out_vec[i] <= '0;
			end else if (neg_dn[NDS][i]) begin
				out_vec[i] <= -UW'(q_dn[NDS][i]);
			end else begin
				out_vec[i] <= UW'(q_dn[NDS][i]);
			end
		end
		out_pay <= pay_dn[NDS];
	end

endmodule

`default_nettype wire

### design/lav_checker.sv
// Port-level checks for the look-at view matrix block, bound to its top level.
// Depends on lav_pkg and look_at_view_matrix_top.
`timescale 1ns / 1ps
`default_nettype none

module lav_checker #(
	parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               row_valid,
	input logic [1:0]         row_index,
	input logic signed [31:0] col0,
	input logic signed [31:0] col1,
	input logic signed [31:0] col2,
	input logic signed [31:0] col3,
	input logic               degenerate,
	input logic               last_row
);

	// rows of one matrix come out back to back, in order
	a_row_seq: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && (row_index != lav_pkg::ROW_HOM)
		|=> row_valid && (row_index == $past(row_index) + 2'd1))
		else $error("row sequence broken");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		last_row |-> row_valid && (row_index == lav_pkg::ROW_HOM))
		else $error("last_row off the final row");

	a_deg_same: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && (row_index != lav_pkg::ROW_SIDE) |-> degenerate == $past(degenerate))
		else $error("degenerate changed within a matrix");

	a_hom_row: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && (row_index == lav_pkg::ROW_HOM)
		|-> (col0 == 32'sd0) && (col1 == 32'sd0) && (col2 == 32'sd0)
			&& (col3 == (32'sd1 <<< FRAC_BITS)))
		else $error("bottom row is not 0 0 0 1");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken without busy");

endmodule

bind look_at_view_matrix_top lav_checker #(.FRAC_BITS(FRAC_BITS)) u_lav_checker (.*);

`default_nettype wire

### tb/sv/look_at_view_matrix_checker.sv
// Checker for the look-at view matrix block: watches requests and rows,
// predicts the four matrix rows per request and compares. Depends on lav_pkg.
`timescale 1ns / 1ps

module look_at_view_matrix_checker #(
	parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	input  logic               row_valid,
	input  logic [1:0]         row_index,
	input  logic signed [31:0] col0,
	input  logic signed [31:0] col1,
	input  logic signed [31:0] col2,
	input  logic signed [31:0] col3,
	input  logic               degenerate,
	input  logic               last_row,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		lav_pkg::row_t     idx;
		logic signed [31:0] c0, c1, c2, c3;
		logic              degen;
		logic              last;
	} mrow_t;

	typedef logic signed [127:0] wide_t;

	mrow_t rows_due[$];

	function automatic logic [127:0] mag_of(wide_t v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic wide_t round_away(wide_t v);
		logic [127:0] m;
		m = (mag_of(v) + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return (v < 0) ? -wide_t'(m) : wide_t'(m);
	endfunction

	function automatic logic signed [31:0] sat32(wide_t v);
		if (v > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -128'sh80000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// unit vector with FRAC_BITS fraction bits; flags a zero vector
	task automatic unit_vec(input wide_t v[3], output wide_t q[3], output logic zero);
		logic [127:0] m[3];
		logic [127:0] mx, len, sum, t;
		int bl;
		mx = 0;
		sum = 0;
		bl = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = mag_of(v[i]);
			if (m[i] > mx) mx = m[i];
		end
		zero = (mx == 0);
		if (zero) begin
			for (int i = 0; i < 3; i++) q[i] = 0;
			return;
		end
		while ((mx >> bl) != 0) bl++;
		for (int i = 0; i < 3; i++) begin
			if (bl > lav_pkg::NORM_BITS) m[i] >>= (bl - lav_pkg::NORM_BITS);
			else m[i] <<= (lav_pkg::NORM_BITS - bl);
			sum += m[i] * m[i];
		end
		len = int_sqrt(sum[63:0]);
		for (int i = 0; i < 3; i++) begin
			t = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
			q[i] = (v[i] < 0) ? -wide_t'(t) : wide_t'(t);
		end
	endtask

	function automatic void cross3(input wide_t a[3], input wide_t b[3], output wide_t r[3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	task automatic predict_matrix();
		wide_t e[3], d[3], up[3], f[3], un[3], raw[3], s[3], u[3];
		wide_t t3[4];
		logic z0, z1, z2, dg;
		mrow_t r;
		e[0] = eye_x; e[1] = eye_y; e[2] = eye_z;
		d[0] = wide_t'(target_x) - e[0];
		d[1] = wide_t'(target_y) - e[1];
		d[2] = wide_t'(target_z) - e[2];
		up[0] = up_x; up[1] = up_y; up[2] = up_z;
		unit_vec(d, f, z0);
		unit_vec(up, un, z1);
		cross3(f, un, raw);
		unit_vec(raw, s, z2);
		cross3(s, f, raw);
		for (int i = 0; i < 3; i++) u[i] = round_away(raw[i]);
		dg = z0 | z1 | z2;
		t3[0] = -round_away(s[0] * e[0] + s[1] * e[1] + s[2] * e[2]);
		t3[1] = -round_away(u[0] * e[0] + u[1] * e[1] + u[2] * e[2]);
		t3[2] = round_away(f[0] * e[0] + f[1] * e[1] + f[2] * e[2]);
		t3[3] = wide_t'(1) << FRAC_BITS;
		for (int k = 0; k < 4; k++) begin
			r.idx = lav_pkg::row_t'(k);
			r.degen = dg;
			r.last = (k == 3);
			r.c3 = sat32(t3[k]);
			case (k)
				0: begin r.c0 = sat32(s[0]); r.c1 = sat32(s[1]); r.c2 = sat32(s[2]); end
				1: begin r.c0 = sat32(u[0]); r.c1 = sat32(u[1]); r.c2 = sat32(u[2]); end
				2: begin r.c0 = sat32(-f[0]); r.c1 = sat32(-f[1]); r.c2 = sat32(-f[2]); end
				default: begin r.c0 = 0; r.c1 = 0; r.c2 = 0; end
			endcase
			rows_due.push_back(r);
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial errors = 0;
	assign pending = rows_due.size();

	always @(posedge clk) begin
		mrow_t w;
		if (arst_n) begin
			if (start && !busy) predict_matrix();
			if (row_valid) begin
				if (rows_due.size() == 0)
					report("unexpected row", row_index, 0);
				else begin
					w = rows_due.pop_front();
					if (row_index != w.idx) report("row_index", row_index, w.idx);
					if (col0 != w.c0) report("col0", col0, w.c0);
					if (col1 != w.c1) report("col1", col1, w.c1);
					if (col2 != w.c2) report("col2", col2, w.c2);
					if (col3 != w.c3) report("col3", col3, w.c3);
					if (degenerate != w.degen) report("degenerate", degenerate, w.degen);
					if (last_row != w.last) report("last_row", last_row, w.last);
				end
			end
		end
	end

endmodule

### tb/sv/look_at_view_matrix_top_test.sv
// Testbench top for the look-at view matrix block: clock, reset, request stimulus
// and verdict. Depends on lav_pkg, look_at_view_matrix_top and the checker.
`timescale 1ns / 1ps

module look_at_view_matrix_top_test;

	logic clk, arst_n, start, busy;
	logic signed [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
	logic row_valid, degenerate, last_row;
	logic [1:0] row_index;
	logic signed [31:0] col0, col1, col2, col3;
	int errors, pending;
	logic quiet;   // long stretch with no idle gaps

	look_at_view_matrix_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.eye_x(ex), .eye_y(ey), .eye_z(ez),
		.target_x(tx), .target_y(ty), .target_z(tz),
		.up_x(ux), .up_y(uy), .up_z(uz),
		.row_valid(row_valid), .row_index(row_index),
		.col0(col0), .col1(col1), .col2(col2), .col3(col3),
		.degenerate(degenerate), .last_row(last_row)
	);

	look_at_view_matrix_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.eye_x(ex), .eye_y(ey), .eye_z(ez),
		.target_x(tx), .target_y(ty), .target_z(tz),
		.up_x(ux), .up_y(uy), .up_z(uz),
		.row_valid(row_valid), .row_index(row_index),
		.col0(col0), .col1(col1), .col2(col2), .col3(col3),
		.degenerate(degenerate), .last_row(last_row),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// hard stop; sized for ~220 spaced requests through the pipeline
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// random coordinate: mostly moderate Q16.16 values, sometimes full range or tiny
	function automatic logic signed [31:0] rnd_coord();
		case ($urandom_range(0, 9))
			0, 1: return $urandom();
			2: return $signed($urandom_range(0, 16)) - 8;
			default: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
		endcase
	endfunction

	// present one request and hold it until accepted; gaps before it at random
	task automatic send_request(input logic signed [31:0] v[9]);
		while (!quiet && $urandom_range(0, 99) < 14) @(negedge clk);
		{ex, ey, ez, tx, ty, tz, ux, uy, uz} = {v[0], v[1], v[2], v[3], v[4], v[5],
			v[6], v[7], v[8]};
		start = 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		start = 0;
	endtask

	initial begin
		logic signed [31:0] v[9];
		logic signed [31:0] mx, mn;
		int wait_cyc;
		mx = 32'sh7FFFFFFF;
		mn = 32'sh80000000;
		quiet = 0;
		start = 0;
		{ex, ey, ez, tx, ty, tz, ux, uy, uz} = '0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: ordinary view, target equal to eye, zero up, up parallel to
		// forward, and extreme coordinates that saturate the translation terms
		v = '{0, 0, 32'sh50000, 0, 0, 0, 0, 32'sh10000, 0};                 send_request(v);
		v = '{32'sh10000, 32'sh20000, 3, 32'sh10000, 32'sh20000, 3, 0, 1, 0}; send_request(v);
		v = '{1, 2, 3, 4, 5, 6, 0, 0, 0};                                     send_request(v);
		v = '{0, 0, 0, 0, 0, 32'sh10000, 0, 0, 32'sh30000};                   send_request(v);
		v = '{0, 0, 0, 0, 0, 32'sh10000, 0, 0, mn};                           send_request(v);
		v = '{mx, mx, mx, mn, mn, mn, mn, mx, 0};                             send_request(v);
		v = '{mn, mn, mn, mx, mx, mx, mx, mn, mx};                            send_request(v);
		v = '{mn, 0, mx, mx, 1, mn, 1, 1, 1};                                 send_request(v);
		v = '{mx, mn, 0, mn, mx, -1, -1, -1, mn};                             send_request(v);
		v = '{-1, -1, -1, 0, 0, 0, mx, mx, mx};                               send_request(v);
		v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                                     send_request(v);
		v = '{-32'sh10000, 0, 0, 0, -32'sh10000, 0, 0, 0, -1};                send_request(v);

		for (int n = 0; n < 210; n++) begin
			quiet = (n >= 80 && n < 130);
			for (int i = 0; i < 9; i++) v[i] = rnd_coord();
			case ($urandom_range(0, 19))
				0: begin v[3] = v[0]; v[4] = v[1]; v[5] = v[2]; end   // target at eye
				1: begin v[6] = 0; v[7] = 0; v[8] = 0; end            // no up
				2: begin                                              // up along forward
					v[0] = 0; v[1] = 0; v[2] = 0;
					v[6] = v[3]; v[7] = v[4]; v[8] = v[5];
				end
				default: ;
			endcase
			send_request(v);
		end
		quiet = 0;

		wait_cyc = 0;
		while (pending != 0 && wait_cyc < 5000) begin
			@(posedge clk);
			wait_cyc++;
		end
		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
design/lav_pkg.sv
design/lav_isqrt.sv
design/lav_norm.sv
design/look_at_view_matrix_top.sv
design/lav_checker.sv
tb/sv/look_at_view_matrix_checker.sv
tb/sv/look_at_view_matrix_top_test.sv
